// ===== hw/rtl/event_graph_topological_sort_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef EVENT_GRAPH_TOPOLOGICAL_SORT_DEFINES_SVH
`define EVENT_GRAPH_TOPOLOGICAL_SORT_DEFINES_SVH
// sampled on clk_i, off while rst_ni is low
`define EGTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// sampled on clk_i, also checked during reset
`define EGTS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`endif

// ===== hw/rtl/egts_pkg.sv =====
`timescale 1ns / 1ps
package egts_pkg;
  localparam int unsigned MaxEvents = 64;
  localparam int unsigned IdBits    = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CntW      = 7;

  typedef struct packed {
    logic [63:0] evt_key;
    logic        has_parent;
    logic [63:0] par_key;
    logic        last_event;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] order_index;
    logic            order_last;
    logic            cycle_found;
    logic [CntW-1:0] duplicate_count;
    logic [CntW-1:0] dangling_count;
  } out_req_t;

  typedef enum logic [11:0] {
    StLoad  = 12'b000000000001,
    StIdKey = 12'b000000000010,
    StIdCap = 12'b000000000100,
    StIdCmp = 12'b000000001000,
    StIdEnd = 12'b000000010000,
    StRoots = 12'b000000100000,
    StPop   = 12'b000001000000,
    StNode  = 12'b000010000000,
    StScan  = 12'b000100000000,
    StOutRd = 12'b001000000000,
    StOut   = 12'b010000000000,
    StDrain = 12'b100000000000
  } state_e;
endpackage

// ===== hw/rtl/event_graph_topological_sort.sv =====
`timescale 1ns / 1ps
// Loading: a new event request is accepted every clock; a non-last event produces no result.
// Closing a batch of n events: id/parent resolution, then a pass for the roots, then a child
// scan per ordered node, then one result per event in order (a single result if a cycle
// is found), stretched by output backpressure.
// One batch at a time: the input reopens once the final result is accepted.
// Reset (rst_ni low, async) clears control and counters; memories are not cleared.
module event_graph_topological_sort (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  egts_pkg::in_req_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output egts_pkg::out_req_t  out_data_o
);
  import egts_pkg::*;

  logic [IdBits-1:0] id_mem [MaxEvents];
  logic [IdBits:0]   pid_mem [MaxEvents];   // {has_parent, parent id}
  logic [IdxW:0]     link_mem [MaxEvents];  // {linked, parent slot}
  logic [IdxW-1:0]   queue_mem [MaxEvents];
  logic [IdBits-1:0] id_rd_q;
  logic [IdBits:0]   pid_rd_q;
  logic [IdxW:0]     link_rd_q;
  logic [IdxW-1:0]   q_rd_q;
  logic [IdxW-1:0]   id_ra, q_ra;
  logic              id_we, link_we, q_we;

  state_e st_q, st_d;
  logic [CntW-1:0]   n_q, n_d, i_q, i_d, j_q, j_d, ci_q, ci_d;
  logic [CntW-1:0]   head_q, head_d, tail_q, tail_d, dup_q, dup_d, dang_q, dang_d;
  logic              lv_q, lv_d, phas_q, phas_d, dhit_q, dhit_d, lhit_q, lhit_d;
  logic [IdBits-1:0] key_q, key_d, pkey_q, pkey_d;
  logic [IdxW-1:0]   slot_q, slot_d, node_q, node_d;
  logic              out_valid_q, out_valid_d;
  out_req_t          out_data_q, out_data_d;

  assign in_ready_o  = (st_q == StLoad);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[n_q[IdxW-1:0]]  <= in_data_i.evt_key[IdBits-1:0];
      pid_mem[n_q[IdxW-1:0]] <= {in_data_i.has_parent, in_data_i.par_key[IdBits-1:0]};
    end
    id_rd_q  <= id_mem[id_ra];
    pid_rd_q <= pid_mem[i_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[i_q[IdxW-1:0]] <= {lhit_q, slot_q};
    link_rd_q <= link_mem[j_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[tail_q[IdxW-1:0]] <= ci_q[IdxW-1:0];
    q_rd_q <= queue_mem[q_ra];
  end

  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; j_d = j_q; ci_d = ci_q; lv_d = lv_q;
    head_d = head_q; tail_d = tail_q; dup_d = dup_q; dang_d = dang_q;
    key_d = key_q; pkey_d = pkey_q; phas_d = phas_q; dhit_d = dhit_q; lhit_d = lhit_q;
    slot_d = slot_q; node_d = node_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;
    id_we = 1'b0; link_we = 1'b0; q_we = 1'b0;
    id_ra = j_q[IdxW-1:0];
    q_ra  = i_q[IdxW-1:0];
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (st_q)
      StLoad: begin
        if (in_valid_i) begin
          // events past MaxEvents are dropped, but a last one still closes the batch
          if (n_q < CntW'(MaxEvents)) begin
            id_we = 1'b1;
            n_d   = n_q + 1'b1;
          end
          if (in_data_i.last_event) begin
            i_d = '0; dup_d = '0; dang_d = '0;
            st_d = StIdKey;
          end
        end
      end
      StIdKey: begin
        id_ra = i_q[IdxW-1:0];
        j_d   = '0;
        st_d  = StIdCap;
      end
      StIdCap: begin
        key_d  = id_rd_q;
        pkey_d = pid_rd_q[IdBits-1:0];
        phas_d = pid_rd_q[IdBits];
        dhit_d = 1'b0; lhit_d = 1'b0; slot_d = '0;
        ci_d = j_q; j_d = j_q + 1'b1;
        st_d = StIdCmp;
      end
      StIdCmp: begin
        // id_rd_q holds id[ci]; the first match of the parent id is its first holder
        if (ci_q < i_q && id_rd_q == key_q) dhit_d = 1'b1;
        if (phas_q && !lhit_q && id_rd_q == pkey_q) begin
          lhit_d = 1'b1;
          slot_d = ci_q[IdxW-1:0];
        end
        if (ci_q + 1'b1 == n_q) begin
          st_d = StIdEnd;
        end else begin
          ci_d = j_q; j_d = j_q + 1'b1;
        end
      end
      StIdEnd: begin
        link_we = 1'b1;
        if (dhit_q) dup_d = dup_q + 1'b1;
        if (phas_q && !lhit_q) dang_d = dang_q + 1'b1;
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == n_q) begin
          j_d = '0; lv_d = 1'b0; tail_d = '0;
          st_d = StRoots;
        end else begin
          st_d = StIdKey;
        end
      end
      StRoots: begin
        if (lv_q && !link_rd_q[IdxW]) begin
          q_we   = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        if (j_q < n_q) begin
          ci_d = j_q; j_d = j_q + 1'b1; lv_d = 1'b1;
        end else begin
          lv_d = 1'b0; head_d = '0;
          st_d = StPop;
        end
      end
      StPop: begin
        q_ra = head_q[IdxW-1:0];
        if (head_q >= tail_q) begin
          i_d  = '0;
          st_d = StOutRd;
        end else begin
          st_d = StNode;
        end
      end
      StNode: begin
        node_d = q_rd_q;
        j_d = '0; lv_d = 1'b0;
        st_d = StScan;
      end
      StScan: begin
        if (lv_q && link_rd_q[IdxW] && link_rd_q[IdxW-1:0] == node_q &&
            tail_q < CntW'(MaxEvents)) begin
          q_we   = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        if (j_q < n_q) begin
          ci_d = j_q; j_d = j_q + 1'b1; lv_d = 1'b1;
        end else begin
          lv_d = 1'b0; head_d = head_q + 1'b1;
          st_d = StPop;
        end
      end
      StOutRd: begin
        st_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d.duplicate_count = dup_q;
          out_data_d.dangling_count  = dang_q;
          if (tail_q != n_q) begin
            out_data_d.order_index = '0;
            out_data_d.order_last  = 1'b1;
            out_data_d.cycle_found = 1'b1;
            st_d = StDrain;
          end else begin
            out_data_d.order_index = q_rd_q;
            out_data_d.order_last  = (i_q + 1'b1 == n_q);
            out_data_d.cycle_found = 1'b0;
            i_d = i_q + 1'b1;
            st_d = (i_q + 1'b1 == n_q) ? StDrain : StOutRd;
          end
        end
      end
      StDrain: begin
        if (!out_valid_q || out_ready_i) begin
          n_d = '0; dup_d = '0; dang_d = '0;
          st_d = StLoad;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      n_q <= '0; i_q <= '0; j_q <= '0; ci_q <= '0; lv_q <= 1'b0;
      head_q <= '0; tail_q <= '0; dup_q <= '0; dang_q <= '0;
      key_q <= '0; pkey_q <= '0; phas_q <= 1'b0; dhit_q <= 1'b0; lhit_q <= 1'b0;
      slot_q <= '0; node_q <= '0;
      out_valid_q <= 1'b0; out_data_q <= '0;
    end else begin
      st_q <= st_d;
      n_q <= n_d; i_q <= i_d; j_q <= j_d; ci_q <= ci_d; lv_q <= lv_d;
      head_q <= head_d; tail_q <= tail_d; dup_q <= dup_d; dang_q <= dang_d;
      key_q <= key_d; pkey_q <= pkey_d; phas_q <= phas_d; dhit_q <= dhit_d; lhit_q <= lhit_d;
      slot_q <= slot_d; node_q <= node_d;
      out_valid_q <= out_valid_d; out_data_q <= out_data_d;
    end
  end
endmodule

// ===== hw/rtl/egts_checker.sv =====
`timescale 1ns / 1ps
`include "event_graph_topological_sort_defines.svh"
module egts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input egts_pkg::out_req_t out_data_o
);
  import egts_pkg::*;
  `EGTS_ASSERT(a_no_in_while_out, out_valid_o |-> !in_ready_o)
  `EGTS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `EGTS_ASSERT(a_cycle_last, out_valid_o && out_data_o.cycle_found |-> out_data_o.order_last)
  `EGTS_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i)
  `EGTS_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o)
endmodule

bind event_graph_topological_sort egts_checker u_egts_checker (.*);

// ===== dv/tb_event_graph_topological_sort.sv =====
`timescale 1ns / 1ps
module tb_event_graph_topological_sort;
  import egts_pkg::*;

  typedef struct {
    in_req_t req;
    bit      drain_first;  // hold off until every expected result has come
    bit      no_gap;
  } pend_item_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b1;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_data_o;

  event_graph_topological_sort dut (.*);

  initial forever #5 clk_i = ~clk_i;

  pend_item_t pend_q[$];
  out_req_t   order_q[$];

  // shadow of the current batch
  logic [63:0] ld_id [MaxEvents];
  logic [63:0] ld_par[MaxEvents];
  bit          ld_has[MaxEvents];
  int          ld_n = 0;

  int  mismatches = 0, results_seen = 0, batches = 0, cycle_batches = 0;
  int  idle_cycles = 0, gap_cnt = 0, hold_cnt = 0;
  bit  feed_done = 0, hold_done = 0;
  localparam int WatchdogLimit = 200000;

  task automatic resolve_batch();
    bit         first[MaxEvents];
    bit         linked[MaxEvents];
    int         slot[MaxEvents];
    int         order[MaxEvents];
    int         dups, dang, head, tail;
    out_req_t   r;
    dups = 0; dang = 0; head = 0; tail = 0;
    for (int i = 0; i < ld_n; i++) begin
      first[i] = 1;
      for (int j = 0; j < i; j++)
        if (first[i] && ld_id[j] == ld_id[i]) begin
          first[i] = 0;
          dups++;
        end
    end
    for (int i = 0; i < ld_n; i++) begin
      linked[i] = 0;
      slot[i] = 0;
      if (ld_has[i]) begin
        for (int j = 0; j < ld_n; j++)
          if (!linked[i] && first[j] && ld_id[j] == ld_par[i]) begin
            linked[i] = 1;
            slot[i] = j;
          end
        if (!linked[i]) dang++;
      end
    end
    for (int i = 0; i < ld_n; i++)
      if (!linked[i]) order[tail++] = i;
    while (head < tail) begin
      int node;
      node = order[head++];
      for (int j = 0; j < ld_n; j++)
        if (linked[j] && slot[j] == node && tail < MaxEvents) order[tail++] = j;
    end
    r.duplicate_count = CntW'(dups);
    r.dangling_count  = CntW'(dang);
    if (tail != ld_n) begin
      r.order_index = '0;
      r.order_last  = 1'b1;
      r.cycle_found = 1'b1;
      order_q = {order_q, r};
      cycle_batches++;
    end else begin
      for (int i = 0; i < ld_n; i++) begin
        r.order_index = IdxW'(order[i]);
        r.order_last  = (i + 1 == ld_n) ? 1'b1 : 1'b0;
        r.cycle_found = 1'b0;
        order_q = {order_q, r};
      end
    end
    batches++;
    ld_n = 0;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    bit accepted, next_valid;
    int r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt = 0;
    end else begin
      accepted = in_valid_i && in_ready_o;
      next_valid = in_valid_i;
      if (accepted) begin
        if (ld_n < MaxEvents) begin
          ld_id[ld_n]  = in_data_i.evt_key;
          ld_par[ld_n] = in_data_i.par_key;
          ld_has[ld_n] = in_data_i.has_parent;
          ld_n++;
        end
        if (in_data_i.last_event) resolve_batch();
      end
      if (!in_valid_i || accepted) begin
        next_valid = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pend_q.size() > 0) begin
          if (!(pend_q[0].drain_first && order_q.size() != 0)) begin
            in_data_i <= pend_q[0].req;
            next_valid = 1'b1;
            r = $urandom_range(0, 9);
            if (pend_q[0].no_gap) gap_cnt = 0;
            else if (r < 6) gap_cnt = 0;
            else if (r < 9) gap_cnt = $urandom_range(1, 3);
            else gap_cnt = $urandom_range(10, 40);
            pend_q.delete(0);
          end
        end else begin
          feed_done = 1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    out_req_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (order_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          exp_r = order_q[0];
          order_q.delete(0);
          if (out_data_o !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data_o);
          end
        end
      end
      if (!hold_done && results_seen >= 20) begin
        hold_done = 1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 14) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          if (r == 19) hold_cnt = $urandom_range(10, 60);
          else hold_cnt = $urandom_range(0, 3);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_event(logic [63:0] id, bit has, logic [63:0] par, bit last,
                           bit drain = 0, bit no_gap = 0);
    pend_item_t p;
    p.req.evt_key    = id;
    p.req.has_parent = has;
    p.req.par_key    = par;
    p.req.last_event = last;
    p.drain_first    = drain;
    p.no_gap         = no_gap;
    pend_q = {pend_q, p};
  endtask

  // random batch: forest (parents from earlier slots) or free graph
  task automatic add_batch(int n, bit forest, bit no_gap, bit drain);
    logic [63:0] ids[$];
    logic [63:0] par;
    int r, k;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) ids = {ids, ids[$urandom_range(0, i - 1)]};
      else ids = {ids, rand64()};
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      par = rand64();
      if (r < 14) begin
        if (forest) begin
          if (i > 0) par = ids[$urandom_range(0, i - 1)];
          else r = 19;
        end else begin
          k = $urandom_range(0, n - 1);
          par = ids[k];
        end
      end
      add_event(ids[i], r < 17, par, i == n - 1, drain && i == 0, no_gap);
    end
  endtask

  initial begin
    int n;
    // directed
    add_event('0, 0, '1, 1);                         // single root
    add_event('1, 1, '1, 1);                         // self parent
    add_event(64'h1, 1, 64'h2, 0);                   // two-node loop
    add_event(64'h2, 1, 64'h1, 1);
    add_event(64'hA, 0, '0, 0);                      // duplicates and dangling
    add_event(64'hA, 1, 64'hA, 0);
    add_event(64'hB, 1, 64'hDEAD, 0);
    add_event(64'hC, 1, 64'hA, 0);
    add_event(64'h0, 1, 64'hB, 1);
    add_event(64'h5555_5555_5555_5555, 1, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    add_event(64'hAAAA_AAAA_AAAA_AAAA, 0, 64'h5555_5555_5555_5555, 0);
    add_event(64'h8000_0000_0000_0000, 1, 64'h5555_5555_5555_5555, 1);
    // overflow: 65th event dropped but still closes the batch
    for (int i = 0; i < MaxEvents + 1; i++)
      add_event(64'(i), i > 0, 64'(i - 1), i == MaxEvents, i == 0);
    // random
    for (int b = 0; b < 30; b++) begin
      n = (b % 18 == 17) ? MaxEvents : $urandom_range(1, 6);
      add_batch(n, $urandom_range(0, 1), b < 5, b == 20);
    end
    add_event(rand64(), 0, rand64(), 1, 0, 0);

    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (feed_done && !in_valid_i && order_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d batches (%0d with a cycle), %0d ordered results, incl. overflow",
             batches, cycle_batches, results_seen);
    if (mismatches == 0 && order_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, order_q.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== event_graph_topological_sort.f =====
+incdir+hw/rtl
hw/rtl/egts_pkg.sv
hw/rtl/event_graph_topological_sort.sv
hw/rtl/egts_checker.sv
dv/tb_event_graph_topological_sort.sv
